/* rtl/core/rih_pkg.sv */
// ----------------------------------------------------------------------------
// rih_pkg
// Shared types and codes of the reflection index hit table.
// ----------------------------------------------------------------------------
`default_nettype none

package rih_pkg;

  // Item modes carried on the input tuser.
  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Result status codes carried on the output tuser.
  localparam logic [2:0] ST_REJECTED = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_IMPROVED = 3'd2;
  localparam logic [2:0] ST_KEPT     = 3'd3;
  localparam logic [2:0] ST_DROPPED  = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;
  localparam logic [2:0] ST_CLEARED  = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_AXIS_A = 3'd0;
  localparam logic [2:0] REG_AXIS_B = 3'd1;
  localparam logic [2:0] REG_AXIS_C = 3'd2;
  localparam logic [2:0] REG_LIMIT  = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  localparam int IDX_W   = 10;
  localparam int COMP_W  = 21;
  localparam int Q_W     = 24;
  localparam int SUM_W   = 48;
  localparam int KEY_W   = 3 * IDX_W;
  localparam int HIT_W   = 52;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_RND, S_SQ, S_SACC, S_JUDGE, S_SCAN, S_HIT, S_MISS,
    S_RDREQ, S_FIN
  } ctrl_state_t;

  // Where the hit fields of a result come from.
  typedef enum logic [1:0] {
    RES_PIX, RES_STORED, RES_READ, RES_ZERO
  } res_sel_t;

  typedef struct packed {
    logic       ld_in;
    logic [1:0] axis_sel;
    logic [1:0] comp_sel;
    logic       mul_en;
    logic       acc_clr;
    logic       acc_add;
    logic       rnd_en;
    logic       sq_en;
    logic       sq_add;
    logic       dsq_clr;
    logic       scan_clr;
    logic       scan_rd;
    logic       entry_rd;
    logic       wr_new;
    logic       wr_upd;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       ovf_set;
    logic       out_load;
    res_sel_t   res_sel;
    logic [2:0] status;
  } rih_cmd_t;

  typedef struct packed {
    logic judge_ok;
    logic scan_more;
    logic match;
    logic better;
    logic full;
    logic entry_ok;
    logic out_free;
  } rih_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rih_ctrl.sv */
// ----------------------------------------------------------------------------
// rih_ctrl
// Sequencer: dot products, rounding, table scan, update and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rih_ctrl
  import rih_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire logic [1:0] in_mode,
  output logic           in_rdy,
  input  rih_stat_t      stat,
  output rih_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic        chk_r, chk_nxt;
  logic [2:0]  st_r, st_nxt;
  res_sel_t    sel_r, sel_nxt;
  logic        issue;

  // Hold state and sequencing counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
      chk_r   <= 1'b0;
      st_r    <= ST_EMPTY;
      sel_r   <= RES_ZERO;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      chk_r   <= chk_nxt;
      st_r    <= st_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    axis_nxt     = axis_r;
    chk_nxt      = chk_r;
    st_nxt       = st_r;
    sel_nxt      = sel_r;
    cmd          = '0;
    cmd.res_sel  = sel_r;
    cmd.status   = st_r;
    cmd.axis_sel = axis_r;
    cmd.comp_sel = cnt_r;
    in_rdy       = 1'b0;
    issue        = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.ld_in = 1'b1;
          cnt_nxt   = '0;
          axis_nxt  = '0;
          case (in_mode)
            MODE_PIXEL: begin
              cmd.dsq_clr = 1'b1;
              state_nxt   = S_MAC;
            end
            MODE_READ: state_nxt = S_RDREQ;
            MODE_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              st_nxt      = ST_CLEARED;
              sel_nxt     = RES_ZERO;
              state_nxt   = S_FIN;
            end
            default: begin
              st_nxt    = ST_EMPTY;
              sel_nxt   = RES_ZERO;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      // Multiply one component per cycle and add each product in the cycle after its multiply.
      S_MAC: begin
        cmd.mul_en  = (cnt_r != 2'd3);
        cmd.acc_clr = (cnt_r == 2'd0);
        cmd.acc_add = (cnt_r != 2'd0);
        cnt_nxt     = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_SACC;
      end
      S_SACC: begin
        cmd.sq_add = 1'b1;
        cnt_nxt    = '0;
        if (axis_r == 2'd2) begin
          state_nxt = S_JUDGE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_MAC;
        end
      end
      S_JUDGE: begin
        sel_nxt = RES_PIX;
        if (!stat.judge_ok) begin
          st_nxt    = ST_REJECTED;
          state_nxt = S_FIN;
        end else begin
          cmd.scan_clr = 1'b1;
          chk_nxt      = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      // Read one entry per cycle; compare the entry read the cycle before.
      S_SCAN: begin
        issue       = stat.scan_more && !(chk_r && stat.match);
        cmd.scan_rd = issue;
        chk_nxt     = issue;
        if (chk_r && stat.match) state_nxt = S_HIT;
        else if (!issue)         state_nxt = S_MISS;
      end
      S_HIT: begin
        if (stat.better) begin
          cmd.wr_upd = 1'b1;
          st_nxt     = ST_IMPROVED;
          sel_nxt    = RES_PIX;
        end else begin
          st_nxt     = ST_KEPT;
          sel_nxt    = RES_STORED;
        end
        state_nxt = S_FIN;
      end
      S_MISS: begin
        sel_nxt = RES_PIX;
        if (stat.full) begin
          cmd.ovf_set = 1'b1;
          st_nxt      = ST_DROPPED;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          st_nxt      = ST_NEW;
        end
        state_nxt = S_FIN;
      end
      S_RDREQ: begin
        if (stat.entry_ok) begin
          cmd.entry_rd = 1'b1;
          st_nxt       = ST_READ;
          sel_nxt      = RES_READ;
        end else begin
          st_nxt       = ST_EMPTY;
          sel_nxt      = RES_ZERO;
        end
        state_nxt = S_FIN;
      end
      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/rih_dp.sv */
// ----------------------------------------------------------------------------
// rih_dp
// Datapath: configuration, index arithmetic, hit table memories, result.
// ----------------------------------------------------------------------------
`default_nettype none

module rih_dp
  import rih_pkg::*;
#(
  parameter int TABLE_DEPTH   = 1024,
  parameter int WINDOW_RADIUS = 3,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_idx,
  input  wire logic [62:0]  cfg_wdata,
  input  wire logic [103:0] in_data,
  input  rih_cmd_t          cmd,
  output rih_stat_t         stat,
  input  wire logic         out_rdy,
  output logic              out_vld,
  output logic [2:0]        out_user,
  output logic [95:0]       out_data
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int DSQ_W  = 2 * FRAC_BITS;
  localparam int SH_DN  = (DSQ_W >= 32) ? DSQ_W - 32 : 0;
  localparam int SH_UP  = (DSQ_W < 32) ? 32 - DSQ_W : 0;
  localparam int PROD_W = Q_W + COMP_W;
  localparam logic signed [SUM_W-1:0] IDX_MIN = -SUM_W'(512);
  localparam logic signed [SUM_W-1:0] IDX_MAX = SUM_W'(511);
  localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS+1:0] ONE  = (FRAC_BITS + 2)'(1) << FRAC_BITS;
  localparam logic [11:0] RAD = 12'(WINDOW_RADIUS);

  // Configuration registers.
  logic [62:0] axis_r [3];
  logic [31:0] limit_r;
  logic [10:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r[0] <= '0;
      axis_r[1] <= '0;
      axis_r[2] <= '0;
      limit_r   <= 32'd42949673;
      width_r   <= 11'd1024;
      height_r  <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_AXIS_A: axis_r[0] <= cfg_wdata;
        REG_AXIS_B: axis_r[1] <= cfg_wdata;
        REG_AXIS_C: axis_r[2] <= cfg_wdata;
        REG_LIMIT:  limit_r   <= cfg_wdata[31:0];
        REG_WIDTH:  width_r   <= cfg_wdata[10:0];
        REG_HEIGHT: height_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Latched input item.
  logic [Q_W-1:0]   q_r [3];
  logic [9:0]       px_r, py_r, ent_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      q_r[0] <= in_data[23:0];
      q_r[1] <= in_data[47:24];
      q_r[2] <= in_data[71:48];
      px_r   <= in_data[81:72];
      py_r   <= in_data[91:82];
      ent_r  <= in_data[101:92];
    end
  end

  // Dot product: one multiply per cycle, product registered, then added.
  logic signed [Q_W-1:0]    q_sel;
  logic signed [COMP_W-1:0] a_sel;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r;

  always_comb begin
    q_sel = $signed(q_r[cmd.comp_sel]);
    a_sel = $signed(axis_r[cmd.axis_sel][COMP_W*cmd.comp_sel +: COMP_W]);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en)  prod_r <= q_sel * a_sel;
    if (cmd.acc_clr) acc_r  <= '0;
    else if (cmd.acc_add) acc_r <= acc_r + SUM_W'(prod_r);
  end

  // Round half to even and form the signed remainder.
  logic signed [SUM_W-1:0]   fl, fl_rnd;
  logic [FRAC_BITS-1:0]      rem;
  logic                      up;
  logic [FRAC_BITS+1:0]      d_full;
  logic signed [FRAC_BITS:0] d_r;
  logic [IDX_W-1:0]          idx_r [3];
  logic                      inrange_r;

  always_comb begin
    fl     = acc_r >>> FRAC_BITS;
    rem    = acc_r[FRAC_BITS-1:0];
    up     = (rem > HALF) || ((rem == HALF) && fl[0]);
    fl_rnd = fl + SUM_W'(up);
    d_full = {2'b00, rem} - (up ? ONE : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) inrange_r <= 1'b1;
    if (cmd.rnd_en) begin
      d_r <= $signed(d_full[FRAC_BITS:0]);
      if (fl_rnd < IDX_MIN) begin
        idx_r[cmd.axis_sel] <= 10'h200;
        inrange_r           <= 1'b0;
      end else if (fl_rnd > IDX_MAX) begin
        idx_r[cmd.axis_sel] <= 10'h1FF;
        inrange_r           <= 1'b0;
      end else begin
        idx_r[cmd.axis_sel] <= fl_rnd[IDX_W-1:0];
      end
    end
  end

  // Square the remainder and sum the three squares.
  logic signed [2*FRAC_BITS+1:0] sq_r;
  logic [DSQ_W-1:0]              dsq_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_en)   sq_r  <= d_r * d_r;
    if (cmd.dsq_clr) dsq_r <= '0;
    else if (cmd.sq_add) dsq_r <= dsq_r + sq_r[DSQ_W-1:0];
  end

  // Limit check and the Q32 distance.
  logic [63:0]     dsq64, dq64, lim64;
  logic [31:0]     dq32;
  logic            accept;
  logic [KEY_W-1:0] key;

  always_comb begin
    dsq64  = 64'(dsq_r);
    dq64   = (dsq64 >> SH_DN) << SH_UP;
    lim64  = 64'(limit_r) << SH_DN;
    accept = (dsq64 << SH_UP) <= lim64;
    dq32   = dq64[31:0];
    key    = {idx_r[0], idx_r[1], idx_r[2]};
  end

  // Table occupancy, overflow and scan pointer.
  logic [CNT_W-1:0] used_r, scan_r;
  logic             ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        used_r <= '0;
        ovf_r  <= 1'b0;
      end else begin
        if (cmd.cnt_inc) used_r <= used_r + CNT_W'(1);
        if (cmd.ovf_set) ovf_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr)     scan_r <= '0;
    else if (cmd.scan_rd) scan_r <= scan_r + CNT_W'(1);
  end

  // Hit table memories: one write and one registered read per cycle.
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [HIT_W-1:0] hit_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_key_r;
  logic [HIT_W-1:0] rd_hit_r;
  logic [AW-1:0]    rd_addr_r, rd_addr, wr_addr;
  logic             rd_en, wr_en;
  logic [HIT_W-1:0] new_hit;

  always_comb begin
    rd_en   = cmd.scan_rd || cmd.entry_rd;
    rd_addr = cmd.entry_rd ? AW'(ent_r) : scan_r[AW-1:0];
    wr_en   = cmd.wr_new || cmd.wr_upd;
    wr_addr = cmd.wr_upd ? rd_addr_r : used_r[AW-1:0];
    new_hit = {px_r, py_r, dq32};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hit_mem[wr_addr] <= new_hit;
      if (cmd.wr_new) key_mem[wr_addr] <= key;
    end
    if (rd_en) begin
      rd_key_r  <= key_mem[rd_addr];
      rd_hit_r  <= hit_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // Status back to the sequencer.
  always_comb begin
    stat.judge_ok  = inrange_r && accept;
    stat.scan_more = scan_r < used_r;
    stat.match     = rd_key_r == key;
    stat.better    = dq32 < rd_hit_r[31:0];
    stat.full      = used_r >= CNT_W'(TABLE_DEPTH);
    stat.entry_ok  = (16'(ent_r) < 16'(used_r)) && (16'(ent_r) < 16'(TABLE_DEPTH));
    stat.out_free  = !out_vld || out_rdy;
  end

  // Result selection and window check.
  logic [IDX_W-1:0] rh, rk, rl;
  logic [9:0]       hx, hy;
  logic [31:0]      hd;
  logic             win;
  logic [11:0]      hx12, hy12;

  always_comb begin
    rh = idx_r[0];
    rk = idx_r[1];
    rl = idx_r[2];
    hx = px_r;
    hy = py_r;
    hd = dq32;
    case (cmd.res_sel)
      RES_PIX: ;
      RES_STORED: begin
        hx = rd_hit_r[51:42];
        hy = rd_hit_r[41:32];
        hd = rd_hit_r[31:0];
      end
      RES_READ: begin
        rh = rd_key_r[29:20];
        rk = rd_key_r[19:10];
        rl = rd_key_r[9:0];
        hx = rd_hit_r[51:42];
        hy = rd_hit_r[41:32];
        hd = rd_hit_r[31:0];
      end
      default: begin
        rh = '0;
        rk = '0;
        rl = '0;
        hx = '0;
        hy = '0;
        hd = '0;
      end
    endcase
    hx12 = 12'(hx);
    hy12 = 12'(hy);
    win  = (hx12 >= RAD) && (hx12 + RAD < 12'(width_r)) &&
           (hy12 >= RAD) && (hy12 + RAD < 12'(height_r)) &&
           (cmd.res_sel != RES_ZERO);
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld <= 1'b1;
    end else if (out_rdy) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_user <= cmd.status;
      out_data <= {1'b0, ovf_r, win, 11'(used_r), hd, hy, hx, rl, rk, rh};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/reflection_index_hit_table_core.sv */
// ----------------------------------------------------------------------------
// reflection_index_hit_table_core
// Miller index hit table: index each pixel, keep the closest pixel per key.
// ----------------------------------------------------------------------------
// For each of the three axes, a pixel item runs a multiply-accumulate on one
// shared multiplier, then rounds the index, squares the remainder and sums it;
// a limit check follows. An accepted item then scans the table at one entry per
// cycle over the key memory's single read port, which sets the cost: the scan
// covers the N entries held (up to TABLE_DEPTH), or stops at the matching key.
// One item is worked on at a time; the result sits in an output register, so
// the next item is accepted while it waits, and a result that is still waiting
// when the next one is ready stalls the block.
// Table memories power up unknown; only entries below the entry count are ever
// read, so no clearing pass is needed.
`default_nettype none

module reflection_index_hit_table_core
  import rih_pkg::*;
#(
  parameter int TABLE_DEPTH   = 1024,
  parameter int WINDOW_RADIUS = 3,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration write channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [62:0]  cfg_data,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // q_u[23:0], q_v[47:24], q_w[71:48], pix_x[81:72], pix_y[91:82],
  // entry_index[101:92], zero fill [103:102]
  input  wire logic [103:0] in_tdata,
  // mode[1:0]
  input  wire logic [1:0]   in_tuser,
  // result items
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // idx_h[9:0], idx_k[19:10], idx_l[29:20], hit_x[39:30], hit_y[49:40],
  // hit_dist_sq[81:50], entry_count[92:82], window_inside[93],
  // overflow_seen[94], zero fill [95]
  output logic [95:0]       out_tdata,
  // status[2:0]
  output logic [2:0]        out_tuser
);

  rih_cmd_t  cmd;
  rih_stat_t stat;
  logic      in_rdy;

  assign cfg_ready = 1'b1;
  assign in_tready = in_rdy;

  rih_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && in_rdy),
    .in_mode (in_tuser),
    .in_rdy  (in_rdy),
    .stat    (stat),
    .cmd     (cmd)
  );

  rih_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .WINDOW_RADIUS (WINDOW_RADIUS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_rdy   (out_tready),
    .out_vld   (out_tvalid),
    .out_user  (out_tuser),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire
